### design/c8_pkg.sv
// c8_pkg: shared constants, types and helpers for the chip8 instruction core
// no dependencies
package c8_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int MEM_BYTES   = 4096;
  localparam int AW          = $clog2(MEM_BYTES);
  localparam int SPW         = $clog2(STACK_DEPTH);
  localparam int SDW         = $clog2(STACK_DEPTH + 1);

  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam logic [15:0] SMALL_FONT = 16'h0050;
  localparam logic [15:0] LARGE_FONT = 16'h00A0;
  localparam logic [15:0] OP_RET     = 16'h00EE;

  localparam logic [1:0] OPER_EXEC  = 2'd0;
  localparam logic [1:0] OPER_TICK  = 2'd1;
  localparam logic [1:0] OPER_WRITE = 2'd2;
  localparam logic [1:0] OPER_READ  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH_HI, ST_FETCH_LO, ST_LATCH, ST_EXEC,
    ST_BCD1, ST_BCD2, ST_LOAD, ST_LOAD_WAIT, ST_READ_WAIT, ST_RET_WAIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [11:0] address;
    logic [7:0] data;
    logic [7:0] random_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] index_value;
    logic [7:0] delay_value;
    logic sound_on;
    logic [7:0] read_data;
    logic stack_fault;
  } out_item_t;

  // memory size is a power of two, so the low address bits wrap it
  function automatic logic [AW-1:0] mem_addr(input logic [16:0] a);
    return a[AW-1:0];
  endfunction

endpackage

### design/c8_if.sv
// c8_if: valid/ready channel carrying one item of a given payload type
// depends on c8_pkg
interface c8_in_if import c8_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  in_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface c8_out_if import c8_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  out_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

### design/c8_ram.sv
// c8_ram: generic single port ram with registered read
// no dependencies
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### design/chip8_instruction_core.sv
// chip8_instruction_core: top level, sequencer around byte memory and stack ram
// depends on c8_pkg, c8_if, c8_ram
//
// channel   dir  payload
// in_ch     in   operation, address, data, random_byte
// out_ch    out  program_counter, index_value, delay_value, sound_on,
//                read_data, stack_fault
//
// the single memory port sets how long an item takes: an instruction makes
// two fetch reads, then one access per bcd digit or loaded register.
// reset clears registers, stack depth and timers; memory is left as is.
// results wait in the output register until taken.
module chip8_instruction_core import c8_pkg::*; (
  input logic clk,
  input logic rst,
  c8_in_if.sink    in_ch,
  c8_out_if.source out_ch
);

  state_t state, state_next;
  in_item_t cur;
  logic [7:0]  v [16];
  logic [15:0] index_reg;
  logic [11:0] pc_reg;
  logic [SDW-1:0] sdepth;
  logic [7:0] dtimer, stimer;
  logic [15:0] opc;
  logic [3:0] cnt;
  logic fault;
  logic [7:0] rdat;

  // memory port
  logic m_we;
  logic [AW-1:0] m_addr;
  logic [7:0] m_wd, m_rd;
  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));

  // return stack
  logic s_we;
  logic [SPW-1:0] s_addr;
  logic [11:0] s_rd;
  c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(pc_reg), .rdata(s_rd));

  logic [3:0] x, y;
  logic [7:0] kk, vx, vy;
  logic [8:0] sum;
  assign x  = opc[11:8];
  assign y  = opc[7:4];
  assign kk = opc[7:0];
  assign vx = v[x];
  assign vy = v[y];
  assign sum = {1'b0, vx} + {1'b0, vy};

  // bcd digits
  logic [7:0] hund, tens, ones;
  always_comb begin
    hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    tens = vx - 8'(hund * 8'd100);
    ones = tens;
    tens = 8'((16'(ones) * 16'd205) >> 11);
    ones = ones - 8'(tens * 8'd10);
  end

  // alu for 8xy_: flag is written first, so sub and shifts see the new flag
  // when an operand is the flag register; the destination write wins
  logic alu_flag_op, alu_flag, alu_wr;
  logic [7:0] fx, fy, alu_res;
  always_comb begin
    alu_flag = 1'b0;
    alu_flag_op = 1'b1;
    alu_wr = 1'b1;
    case (opc[3:0])
      4'h4: alu_flag = sum[8];
      4'h5: alu_flag = (vx > vy);
      4'h6: alu_flag = vx[0];
      4'hE: alu_flag = vx[7];
      default: alu_flag_op = 1'b0;
    endcase
    fx = (x == 4'hF) ? {7'd0, alu_flag} : vx;
    fy = (y == 4'hF) ? {7'd0, alu_flag} : vy;
    case (opc[3:0])
      4'h0: alu_res = vy;
      4'h1: alu_res = vx | vy;
      4'h2: alu_res = vx & vy;
      4'h3: alu_res = vx ^ vy;
      4'h4: alu_res = sum[7:0];
      4'h5: alu_res = fx - fy;
      4'h6: alu_res = fx >> 1;
      4'hE: alu_res = fx << 1;
      default: begin
        alu_res = vx;
        alu_wr = 1'b0;
      end
    endcase
  end

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.item  = '{pc_reg, index_reg, dtimer, stimer != 8'd0, rdat, fault};

  always_comb begin
    state_next = state;
    m_we = 1'b0; m_addr = cur.address; m_wd = cur.data;
    s_we = 1'b0; s_addr = SPW'(sdepth);
    unique case (state)
      ST_IDLE: if (in_ch.valid) state_next = ST_FETCH_HI;
      ST_FETCH_HI: begin
        unique case (cur.operation)
          OPER_EXEC: begin m_addr = mem_addr({5'd0, pc_reg}); state_next = ST_FETCH_LO; end
          OPER_TICK: state_next = ST_OUT;
          OPER_WRITE: begin m_we = 1'b1; state_next = ST_OUT; end
          default: state_next = ST_READ_WAIT;
        endcase
      end
      ST_READ_WAIT: state_next = ST_OUT;
      ST_FETCH_LO: begin m_addr = mem_addr({5'd0, pc_reg + 12'd1}); state_next = ST_LATCH; end
      ST_LATCH: state_next = ST_EXEC;
      ST_EXEC: begin
        state_next = ST_OUT;
        m_addr = mem_addr({1'b0, index_reg});
        unique case (opc[15:12])
          4'h0: if (opc == OP_RET && sdepth != '0) begin
            s_addr = SPW'(sdepth - 1'b1); state_next = ST_RET_WAIT;
          end
          4'h2: if (sdepth < SDW'(STACK_DEPTH)) s_we = 1'b1;
          4'hF: begin
            if (kk == 8'h33) begin m_we = 1'b1; m_wd = hund; state_next = ST_BCD1; end
            if (kk == 8'h65) state_next = ST_LOAD;
          end
          default: ;
        endcase
      end
      ST_BCD1: begin
        m_we = 1'b1; m_wd = tens; m_addr = mem_addr({1'b0, index_reg} + 17'd1);
        state_next = ST_BCD2;
      end
      ST_BCD2: begin
        m_we = 1'b1; m_wd = ones; m_addr = mem_addr({1'b0, index_reg} + 17'd2);
        state_next = ST_OUT;
      end
      ST_LOAD: begin
        m_addr = mem_addr({1'b0, index_reg} + 17'(cnt));
        state_next = ST_LOAD_WAIT;
      end
      ST_LOAD_WAIT: state_next = (cnt == x) ? ST_OUT : ST_LOAD;
      ST_RET_WAIT: state_next = ST_OUT;
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) v[i] <= 8'd0;
      index_reg <= '0; pc_reg <= PC_RESET; sdepth <= '0;
      dtimer <= '0; stimer <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          cur <= in_ch.item; fault <= 1'b0; rdat <= 8'd0; cnt <= 4'd0;
        end
        ST_FETCH_HI: if (cur.operation == OPER_TICK) begin
          if (dtimer != 8'd0) dtimer <= dtimer - 8'd1;
          if (stimer != 8'd0) stimer <= stimer - 8'd1;
        end
        ST_READ_WAIT: rdat <= m_rd;
        ST_FETCH_LO: opc[15:8] <= m_rd;
        ST_LATCH: begin opc[7:0] <= m_rd; pc_reg <= pc_reg + 12'd2; end
        ST_EXEC: begin
          unique case (opc[15:12])
            4'h1: pc_reg <= opc[11:0];
            4'h2: if (sdepth < SDW'(STACK_DEPTH)) begin
              sdepth <= sdepth + 1'b1; pc_reg <= opc[11:0];
            end else fault <= 1'b1;
            4'h3: if (vx == kk) pc_reg <= pc_reg + 12'd2;
            4'h4: if (vx != kk) pc_reg <= pc_reg + 12'd2;
            4'h5: if (vx == vy) pc_reg <= pc_reg + 12'd2;
            4'h6: v[x] <= kk;
            4'h7: v[x] <= vx + kk;
            4'h8: begin
              // flag first, destination write wins when x is the flag
              if (alu_flag_op && x != 4'hF) v[15] <= {7'd0, alu_flag};
              if (alu_wr) v[x] <= alu_res;
            end
            4'hA: index_reg <= {4'd0, opc[11:0]};
            4'hC: v[x] <= cur.random_byte & kk;
            4'hF: case (kk)
              8'h07: v[x] <= dtimer;
              8'h15: dtimer <= vx;
              8'h18: stimer <= vx;
              8'h1E: index_reg <= index_reg + 16'(vx);
              8'h29: index_reg <= SMALL_FONT + 16'(vx) * 16'd5;
              8'h30: index_reg <= LARGE_FONT + 16'(vx) * 16'd10;
              default: ;
            endcase
            default: ;
          endcase
        end
        ST_LOAD_WAIT: begin v[cnt] <= m_rd; cnt <= cnt + 4'd1; end
        ST_RET_WAIT: begin sdepth <= sdepth - 1'b1; pc_reg <= s_rd; end
        default: ;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.item))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while result pending");
  a_depth: assert property (@(posedge clk) disable iff (rst)
    sdepth <= SDW'(STACK_DEPTH))
    else $error("stack depth overflow");

endmodule
